/* rtl/prl_pkg.sv */
`default_nettype none

package prl_pkg;

   localparam int MAX_TASKS = 16;
   localparam int ID_BITS   = 8;
   localparam int PRIO_BITS = 8;

   localparam int IDX_BITS = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_BITS = $clog2(MAX_TASKS + 1);

   localparam int TASK_WORD_BITS  = 8;
   localparam int PRIO_WORD_BITS  = 8;
   localparam int COUNT_WORD_BITS = 5;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_LISTED  = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic step;
      logic ins;
      logic del;
   } dp_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic full;
   } dp_stat_type;

endpackage

`default_nettype wire

/* rtl/prl_ctrl.sv */
`default_nettype none

module prl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               req_func,
   output logic                    busy,
   output prl_pkg::dp_cmd_type     cmd,
   input  wire prl_pkg::dp_stat_type stat,
   output logic                    rsp_valid,
   output prl_pkg::status_type     rsp_status
);
   import prl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE
   } state_type;

   state_type  state_ff;
   logic       func_ff;
   logic       rsp_valid_ff;
   status_type rsp_status_ff;

   always_comb begin
      cmd      = '0;
      cmd.load = (state_ff == S_IDLE) && start;
      cmd.step = (state_ff == S_SCAN) && !stat.scan_done;
      if (state_ff == S_DECIDE) begin
         cmd.ins = (func_ff == FUNC_INSERT) && !stat.found && !stat.full;
         cmd.del = (func_ff == FUNC_DELETE) && stat.found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         func_ff       <= FUNC_INSERT;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= ST_DONE;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff  <= req_func;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
               if (func_ff == FUNC_INSERT) begin
                  priority if (stat.found) rsp_status_ff <= ST_LISTED;
                  else if (stat.full)      rsp_status_ff <= ST_FULL;
                  else                     rsp_status_ff <= ST_DONE;
               end else begin
                  rsp_status_ff <= stat.found ? ST_DONE : ST_MISSING;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

endmodule

`default_nettype wire

/* rtl/prl_datapath.sv */
`default_nettype none

module prl_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire prl_pkg::dp_cmd_type                    cmd,
   output prl_pkg::dp_stat_type                        stat,
   input  wire logic [prl_pkg::TASK_WORD_BITS-1:0]     req_task_id,
   input  wire logic [prl_pkg::PRIO_WORD_BITS-1:0]     req_priority_req,
   output logic [prl_pkg::TASK_WORD_BITS-1:0]          head_task,
   output logic                                        head_valid,
   output logic [prl_pkg::COUNT_WORD_BITS-1:0]         task_count
);
   import prl_pkg::*;

   logic [ID_BITS-1:0]   slot_task_ff [MAX_TASKS];
   logic [ID_BITS-1:0]   slot_task_in [MAX_TASKS];
   logic [PRIO_BITS-1:0] slot_prio_ff [MAX_TASKS];
   logic [PRIO_BITS-1:0] slot_prio_in [MAX_TASKS];

   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;
   logic [CNT_BITS-1:0]  hit_ff, hit_in;
   logic [CNT_BITS-1:0]  pos_ff, pos_in;
   logic                 found_ff, found_in;
   logic                 seen_ff, seen_in;
   logic [ID_BITS-1:0]   req_id_ff, req_id_in;
   logic [PRIO_BITS-1:0] req_prio_ff, req_prio_in;

   logic [ID_BITS-1:0]   rd_task;
   logic [PRIO_BITS-1:0] rd_prio;

   assign rd_task = slot_task_ff[idx_ff[IDX_BITS-1:0]];
   assign rd_prio = slot_prio_ff[idx_ff[IDX_BITS-1:0]];

   always_comb begin
      idx_in      = idx_ff;
      hit_in      = hit_ff;
      pos_in      = pos_ff;
      found_in    = found_ff;
      seen_in     = seen_ff;
      req_id_in   = req_id_ff;
      req_prio_in = req_prio_ff;
      count_in    = count_ff;
      for (int j = 0; j < MAX_TASKS; j++) begin
         slot_task_in[j] = slot_task_ff[j];
         slot_prio_in[j] = slot_prio_ff[j];
      end

      if (cmd.load) begin
         idx_in      = '0;
         hit_in      = '0;
         pos_in      = count_ff;
         found_in    = 1'b0;
         seen_in     = 1'b0;
         req_id_in   = ID_BITS'(req_task_id);
         req_prio_in = PRIO_BITS'(req_priority_req);
      end

      if (cmd.step) begin
         idx_in = idx_ff + CNT_BITS'(1);
         if (rd_task == req_id_ff) begin
            found_in = 1'b1;
            hit_in   = idx_ff;
         end
         if (!seen_ff && (rd_prio < req_prio_ff)) begin
            seen_in = 1'b1;
            pos_in  = idx_ff;
         end
      end

      if (cmd.ins) begin
         for (int j = 1; j < MAX_TASKS; j++) begin
            if (CNT_BITS'(j) > pos_ff) begin
               slot_task_in[j] = slot_task_ff[j-1];
               slot_prio_in[j] = slot_prio_ff[j-1];
            end
         end
         slot_task_in[pos_ff[IDX_BITS-1:0]] = req_id_ff;
         slot_prio_in[pos_ff[IDX_BITS-1:0]] = req_prio_ff;
         count_in = count_ff + CNT_BITS'(1);
      end

      if (cmd.del) begin
         for (int j = 0; j < MAX_TASKS - 1; j++) begin
            if (CNT_BITS'(j) >= hit_ff) begin
               slot_task_in[j] = slot_task_ff[j+1];
               slot_prio_in[j] = slot_prio_ff[j+1];
            end
         end
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      hit_ff      <= hit_in;
      pos_ff      <= pos_in;
      found_ff    <= found_in;
      seen_ff     <= seen_in;
      req_id_ff   <= req_id_in;
      req_prio_ff <= req_prio_in;
      for (int j = 0; j < MAX_TASKS; j++) begin
         slot_task_ff[j] <= slot_task_in[j];
         slot_prio_ff[j] <= slot_prio_in[j];
      end
   end

   assign stat.scan_done = (idx_ff == count_ff);
   assign stat.found     = found_ff;
   assign stat.full      = (count_ff == CNT_BITS'(MAX_TASKS));

   assign head_valid = (count_ff != '0);
   assign head_task  = head_valid ? TASK_WORD_BITS'(slot_task_ff[0]) : '0;
   assign task_count = COUNT_WORD_BITS'(count_ff);

endmodule

`default_nettype wire

/* rtl/priority_ready_list_unit.sv */
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+--------------------------
// request   | req_func, req_task_id, req_priority_req      | taken when start & !busy
// response  | rsp_status, rsp_head_task, rsp_head_valid,   | rsp_valid, one cycle,
//           | rsp_task_count                               | cannot be held off
//
// Each word runs a linear scan over the listed entries, one entry a cycle, then
// shifts the list in a decide state as the response is registered.
// busy falls with rsp_valid, so the next word may start in the response cycle.
// Synchronous reset empties the list; slot contents are not cleared.
// The receiver cannot stall; each response is shown for exactly one cycle.
`default_nettype none

module priority_ready_list_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_func,
   input  wire logic [prl_pkg::TASK_WORD_BITS-1:0]  req_task_id,
   input  wire logic [prl_pkg::PRIO_WORD_BITS-1:0]  req_priority_req,
   output logic                                     rsp_valid,
   output logic [1:0]                               rsp_status,
   output logic [prl_pkg::TASK_WORD_BITS-1:0]       rsp_head_task,
   output logic                                     rsp_head_valid,
   output logic [prl_pkg::COUNT_WORD_BITS-1:0]      rsp_task_count
);
   import prl_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   status_type  status;

   prl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_func   (req_func),
      .busy       (busy),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_status (status)
   );

   prl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .head_task        (rsp_head_task),
      .head_valid       (rsp_head_valid),
      .task_count       (rsp_task_count)
   );

   assign rsp_status = status;

endmodule

`default_nettype wire

/* tb/tb_priority_ready_list_unit.sv */
module tb_priority_ready_list_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import prl_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int POOL_SIZE   = 20;

   typedef struct {
      logic                      func;
      logic [TASK_WORD_BITS-1:0] task_id;
      logic [PRIO_WORD_BITS-1:0] prio;
   } sched_word_type;

   typedef struct {
      status_type                 status;
      logic [TASK_WORD_BITS-1:0]  head_task;
      logic                       head_valid;
      logic [COUNT_WORD_BITS-1:0] task_count;
   } list_view_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_func = 1'b0;
   logic [TASK_WORD_BITS-1:0]  req_task_id = '0;
   logic [PRIO_WORD_BITS-1:0]  req_priority_req = '0;
   logic                       rsp_valid;
   logic [1:0]                 rsp_status;
   logic [TASK_WORD_BITS-1:0]  rsp_head_task;
   logic                       rsp_head_valid;
   logic [COUNT_WORD_BITS-1:0] rsp_task_count;

   priority_ready_list_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_task_id      (req_task_id),
      .req_priority_req (req_priority_req),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_head_task    (rsp_head_task),
      .rsp_head_valid   (rsp_head_valid),
      .rsp_task_count   (rsp_task_count)
   );

   sched_word_type pending_words[$];
   list_view_type  expected_views[$];

   // shadow ready list, head first
   logic [ID_BITS-1:0]   shadow_id[MAX_TASKS];
   logic [PRIO_BITS-1:0] shadow_prio[MAX_TASKS];
   int                   shadow_count = 0;

   bit word_taken = 1'b0;
   int gap_left = 0;
   int calm_left = 0;
   int words_total = 0;
   int words_taken = 0;
   int error_count = 0;
   int cycle_count = 0;
   int deepest = 0;
   int status_seen[4] = '{0, 0, 0, 0};

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int next_gap();
      int roll;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      roll = $urandom_range(99);
      if (roll < 5) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 15);
      return $urandom_range(40, 120);
   endfunction

   task automatic apply_word(input sched_word_type w, output list_view_type v);
      int hit;
      int pos;
      hit = -1;
      for (int i = shadow_count - 1; i >= 0; i--) begin
         if (shadow_id[i] == w.task_id[ID_BITS-1:0]) hit = i;
      end
      if (w.func == FUNC_INSERT) begin
         if (hit >= 0) begin
            v.status = ST_LISTED;
         end else if (shadow_count >= MAX_TASKS) begin
            v.status = ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_count && shadow_prio[pos] >= w.prio[PRIO_BITS-1:0]) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_id[i]   = shadow_id[i-1];
               shadow_prio[i] = shadow_prio[i-1];
            end
            shadow_id[pos]   = w.task_id[ID_BITS-1:0];
            shadow_prio[pos] = w.prio[PRIO_BITS-1:0];
            shadow_count++;
            v.status = ST_DONE;
         end
      end else begin
         if (hit < 0) begin
            v.status = ST_MISSING;
         end else begin
            for (int i = hit; i + 1 < shadow_count; i++) begin
               shadow_id[i]   = shadow_id[i+1];
               shadow_prio[i] = shadow_prio[i+1];
            end
            shadow_count--;
            v.status = ST_DONE;
         end
      end
      v.head_task  = (shadow_count > 0) ? TASK_WORD_BITS'(shadow_id[0]) : '0;
      v.head_valid = (shadow_count > 0);
      v.task_count = COUNT_WORD_BITS'(shadow_count);
   endtask

   task automatic queue_word(input logic func, input int id, input int prio);
      sched_word_type w;
      w.func    = func;
      w.task_id = TASK_WORD_BITS'(id);
      w.prio    = PRIO_WORD_BITS'(prio);
      pending_words.push_back(w);
      words_total++;
   endtask

   // driver
   always @(negedge clock) begin : drive_words
      sched_word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         if (gap_left > 0) begin
            start <= 1'b0;
            gap_left = gap_left - 1;
         end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            req_func         <= w.func;
            req_task_id      <= w.task_id;
            req_priority_req <= w.prio;
            start            <= 1'b1;
            gap_left = next_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and predictor
   always @(posedge clock) begin : watch_words
      list_view_type  want;
      list_view_type  fresh;
      sched_word_type w;
      word_taken = !reset && start && !busy;
      if (!reset && rsp_valid) begin
         if (expected_views.size() == 0) begin
            $error("unexpected response word: status %0d head %0d count %0d",
                   rsp_status, rsp_head_task, rsp_task_count);
            error_count++;
         end else begin
            want = expected_views.pop_front();
            status_seen[want.status]++;
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_head_task !== want.head_task) begin
               $error("rsp_head_task: expected %0d, got %0d", want.head_task, rsp_head_task);
               error_count++;
            end
            if (rsp_head_valid !== want.head_valid) begin
               $error("rsp_head_valid: expected %0d, got %0d", want.head_valid,
                      rsp_head_valid);
               error_count++;
            end
            if (rsp_task_count !== want.task_count) begin
               $error("rsp_task_count: expected %0d, got %0d", want.task_count,
                      rsp_task_count);
               error_count++;
            end
         end
      end
      if (word_taken) begin
         w.func    = req_func;
         w.task_id = req_task_id;
         w.prio    = req_priority_req;
         apply_word(w, fresh);
         expected_views.push_back(fresh);
         if (shadow_count > deepest) deepest = shadow_count;
         words_taken++;
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected", CYCLE_LIMIT,
                  expected_views.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int id_pool[POOL_SIZE];
      int ins_pct;
      logic func;
      int id;
      int prio;

      // directed: empty list, extremes, ties, duplicates, head and tail removal
      queue_word(FUNC_DELETE, 5, 0);
      queue_word(FUNC_INSERT, 0, 0);
      queue_word(FUNC_INSERT, 255, 255);
      queue_word(FUNC_INSERT, 1, 0);
      queue_word(FUNC_INSERT, 0, 200);
      queue_word(FUNC_DELETE, 255, 255);
      queue_word(FUNC_DELETE, 1, 0);
      queue_word(FUNC_DELETE, 0, 0);
      queue_word(FUNC_DELETE, 0, 0);
      // fill to capacity, then refuse a new task and a listed one
      for (int i = 0; i < MAX_TASKS; i++) queue_word(FUNC_INSERT, 10 + i, (i * 37) & 8'hff);
      queue_word(FUNC_INSERT, 200, 255);
      queue_word(FUNC_INSERT, 12, 0);

      // random: small id pools per phase so lists fill, tie and drain
      for (int ph = 0; ph < 12; ph++) begin
         for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = $urandom_range(0, 255);
         ins_pct = $urandom_range(30, 80);
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(99) < 5) begin
               func = 1'($urandom_range(1));
               id   = $urandom_range(0, 255);
               prio = $urandom_range(0, 255);
            end else begin
               func = ($urandom_range(99) < ins_pct) ? FUNC_INSERT : FUNC_DELETE;
               id   = id_pool[$urandom_range(POOL_SIZE - 1)];
               prio = $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
            end
            queue_word(func, id, prio);
         end
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!(words_taken == words_total && expected_views.size() == 0)) @(negedge clock);
      repeat (40) @(posedge clock);

      $display("%0d requests: %0d done, %0d already listed, %0d full, %0d not found",
               words_taken, status_seen[ST_DONE], status_seen[ST_LISTED],
               status_seen[ST_FULL], status_seen[ST_MISSING]);
      $display("deepest list held %0d tasks, %0d mismatches", deepest, error_count);
      if (error_count == 0 && expected_views.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
